// File: sv/cvc_pkg.sv
// Shared widths, codes and types for the chunk visibility cull block.
package cvc_pkg;

	// Field widths fixed by the stream and register formats
	localparam int CHUNK_W    = 16;
	localparam int EYE_W      = 28;
	localparam int DIR_W      = 16;
	localparam int RAD_W      = 20;
	localparam int RR_W       = 2 * RAD_W;
	localparam int F2_W       = 2 * DIR_W;
	localparam int ADDR_W     = 3;
	localparam int CFG_DATA_W = 28;
	localparam int IN_DATA_W  = 2 * CHUNK_W;
	localparam int OUT_DATA_W = 8;

	// Defaults for the top level parameters
	localparam int DEF_CHUNK_SIZE_X  = 16;
	localparam int DEF_CHUNK_SIZE_Z  = 16;
	localparam int DEF_FRACTION_BITS = 8;

	// Radius reset: 256 blocks at 8 fraction bits
	localparam logic [RAD_W-1:0] RAD_RESET = RAD_W'(65536);

	// Near test: center within 24 blocks, squared in doubled units
	localparam int NEAR_BLOCKS  = 24;
	localparam int NEAR_SQ_BASE = (2 * NEAR_BLOCKS) * (2 * NEAR_BLOCKS);

	// Cone limit cos > -7/20, compared as (20 p)^2 < (7 d2)(7 f2)
	localparam int CONE_LHS_K = 400;
	localparam int CONE_RHS_K = 49;

	typedef enum logic [ADDR_W-1:0] {
		REG_EYE_POS_X     = 3'd0,
		REG_EYE_POS_Z     = 3'd1,
		REG_VIEW_DIR_X    = 3'd2,
		REG_VIEW_DIR_Z    = 3'd3,
		REG_RENDER_RADIUS = 3'd4
	} reg_idx_t;

	typedef enum logic [2:0] {
		VERDICT_FAR      = 3'd0,
		VERDICT_NEAR     = 3'd1,
		VERDICT_ZERO_FWD = 3'd2,
		VERDICT_IN_CONE  = 3'd3,
		VERDICT_BEHIND   = 3'd4
	} verdict_t;

	typedef struct packed {
		logic signed [EYE_W-1:0] eye_pos_x;
		logic signed [EYE_W-1:0] eye_pos_z;
		logic signed [DIR_W-1:0] view_dir_x;
		logic signed [DIR_W-1:0] view_dir_z;
		logic        [RAD_W-1:0] render_radius;
	} cfg_t;

endpackage

// File: sv/cvc_cfg.sv
// Camera setup register file with its write decoder.
module cvc_cfg
	import cvc_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [ADDR_W-1:0]     cfg_addr,
	input  logic [CFG_DATA_W-1:0] cfg_wdata,
	output cfg_t                  cfg
);

	cfg_t cfg_q;

	// Register writes; indexes past the list are dropped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.eye_pos_x     <= '0;
			cfg_q.eye_pos_z     <= '0;
			cfg_q.view_dir_x    <= '0;
			cfg_q.view_dir_z    <= '0;
			cfg_q.render_radius <= RAD_RESET;
		end else if (cfg_we) begin
			unique case (reg_idx_t'(cfg_addr))
				REG_EYE_POS_X:     cfg_q.eye_pos_x     <= $signed(cfg_wdata[EYE_W-1:0]);
				REG_EYE_POS_Z:     cfg_q.eye_pos_z     <= $signed(cfg_wdata[EYE_W-1:0]);
				REG_VIEW_DIR_X:    cfg_q.view_dir_x    <= $signed(cfg_wdata[DIR_W-1:0]);
				REG_VIEW_DIR_Z:    cfg_q.view_dir_z    <= $signed(cfg_wdata[DIR_W-1:0]);
				REG_RENDER_RADIUS: cfg_q.render_radius <= cfg_wdata[RAD_W-1:0];
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

// File: sv/chunk_visibility_cull_core.sv
// Top level: pipelined chunk visibility cull against distance and view cone.
//
// One chunk word is accepted per clock while s_tready is high, and its verdict leaves
// from the S9 register; the depth of the nine-stage pipeline is set by
// the exact cone test, whose wide products are built from partial products over
// three stages. A stalled output backs the pipeline up one stage at a time, so
// words keep entering while bubbles remain. Camera registers are written through
// the plain write port and must stay unchanged while words are in flight.
module chunk_visibility_cull_core
	import cvc_pkg::*;
#(
	parameter int CHUNK_SIZE_X  = DEF_CHUNK_SIZE_X,
	parameter int CHUNK_SIZE_Z  = DEF_CHUNK_SIZE_Z,
	parameter int FRACTION_BITS = DEF_FRACTION_BITS
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_tvalid,
	output logic                  s_tready,
	input  logic [IN_DATA_W-1:0]  s_tdata,   // chunk_x [15:0], chunk_z [31:16]
	output logic                  m_tvalid,
	input  logic                  m_tready,
	output logic [OUT_DATA_W-1:0] m_tdata,   // is_visible [0], verdict [3:1], zero pad
	input  logic                  cfg_we,
	input  logic [ADDR_W-1:0]     cfg_addr,
	input  logic [CFG_DATA_W-1:0] cfg_wdata
);

	// Footprint spans and derived widths
	localparam int SPAN_X   = CHUNK_SIZE_X << FRACTION_BITS;
	localparam int SPAN_Z   = CHUNK_SIZE_Z << FRACTION_BITS;
	localparam int SPAN_MAX = (SPAN_X > SPAN_Z) ? SPAN_X : SPAN_Z;
	localparam int SPAN_W   = $clog2(SPAN_MAX + 1);
	localparam int LIM_W    = CHUNK_W + SPAN_W + 1;
	localparam int POS_W    = ((LIM_W > EYE_W + 1) ? LIM_W : EYE_W + 1) + 2;
	localparam int D_W      = ((SPAN_W > RAD_W + 1) ? SPAN_W : RAD_W + 1) + 2;
	localparam int D2_W     = 2 * D_W;
	localparam int PD_W     = D_W + DIR_W;
	localparam int P_W      = PD_W + 1;
	localparam int PA_W     = P_W - 1;
	localparam int PL_W     = (PA_W + 1) / 2;
	localparam int PH_W     = PA_W - PL_W;
	localparam int HH_W     = 2 * PH_W;
	localparam int HL_W     = PH_W + PL_W;
	localparam int LL_W     = 2 * PL_W;
	localparam int P2_W     = 2 * PA_W;
	localparam int DL_W     = (D2_W + 1) / 2;
	localparam int DH_W     = D2_W - DL_W;
	localparam int DFH_W    = DH_W + F2_W;
	localparam int DFL_W    = DL_W + F2_W;
	localparam int Q_W      = D2_W + F2_W;
	localparam int Q49_W    = Q_W + 6;
	localparam int L_W      = P2_W + 9;
	localparam int CMP_W    = ((L_W > Q49_W) ? L_W : Q49_W) + 1;
	localparam int NUM_ST   = 9;

	localparam logic signed [POS_W-1:0] SPAN_X_S = POS_W'(SPAN_X);
	localparam logic signed [POS_W-1:0] SPAN_Z_S = POS_W'(SPAN_Z);
	localparam logic [D2_W-1:0] NEAR2 =
		D2_W'(64'(NEAR_SQ_BASE) << (2 * FRACTION_BITS));

	cfg_t cfg;

	cvc_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_addr  (cfg_addr),
		.cfg_wdata (cfg_wdata),
		.cfg       (cfg)
	);

	// Values that follow from the camera alone, refreshed every clock
	logic [RR_W-1:0] rr_q;
	logic [F2_W-1:0] f2_q;
	logic            fzero_q;
	logic signed [F2_W-1:0] vxx, vzz;

	assign vxx = F2_W'(cfg.view_dir_x) * F2_W'(cfg.view_dir_x);
	assign vzz = F2_W'(cfg.view_dir_z) * F2_W'(cfg.view_dir_z);

	always_ff @(posedge clk) begin
		rr_q    <= RR_W'(cfg.render_radius) * RR_W'(cfg.render_radius);
		f2_q    <= $unsigned(vxx) + $unsigned(vzz);
		fzero_q <= (cfg.view_dir_x == '0) && (cfg.view_dir_z == '0);
	end

	// Stage handshake: a stage loads when it is empty or its successor moves
	logic [NUM_ST:1] vld_q;
	logic [NUM_ST:1] rdy;

	always_comb begin
		rdy[NUM_ST] = ~vld_q[NUM_ST] | m_tready;
		for (int k = NUM_ST - 1; k >= 1; k--) begin
			rdy[k] = ~vld_q[k] | rdy[k+1];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			if (rdy[1]) vld_q[1] <= s_tvalid;
			for (int k = 2; k <= NUM_ST; k++) begin
				if (rdy[k]) vld_q[k] <= vld_q[k-1];
			end
		end
	end

	assign s_tready = rdy[1];
	assign m_tvalid = vld_q[NUM_ST];

	// S1: footprint corner from the chunk index
	logic signed [CHUNK_W-1:0] cx, cz;
	logic signed [POS_W-1:0]   cx_ext, cz_ext;
	logic signed [POS_W-1:0]   minx_s1, minz_s1;

	assign cx     = $signed(s_tdata[CHUNK_W-1:0]);
	assign cz     = $signed(s_tdata[2*CHUNK_W-1:CHUNK_W]);
	assign cx_ext = {{(POS_W-CHUNK_W){cx[CHUNK_W-1]}}, cx};
	assign cz_ext = {{(POS_W-CHUNK_W){cz[CHUNK_W-1]}}, cz};

	always_ff @(posedge clk) begin
		if (rdy[1]) begin
			minx_s1 <= cx_ext * SPAN_X_S;
			minz_s1 <= cz_ext * SPAN_Z_S;
		end
	end

	// S2: clamp eye into footprint, gap and doubled center vector
	logic signed [POS_W-1:0] eyex, eyez, hix, hiz, clx, clz, dxw, dzw;
	logic signed [POS_W-1:0] ndx_s2, ndz_s2;
	logic signed [D_W-1:0]   dx_s2, dz_s2;

	assign eyex = {{(POS_W-EYE_W){cfg.eye_pos_x[EYE_W-1]}}, cfg.eye_pos_x};
	assign eyez = {{(POS_W-EYE_W){cfg.eye_pos_z[EYE_W-1]}}, cfg.eye_pos_z};
	assign hix  = minx_s1 + SPAN_X_S;
	assign hiz  = minz_s1 + SPAN_Z_S;
	assign clx  = (eyex < minx_s1) ? minx_s1 : ((eyex > hix) ? hix : eyex);
	assign clz  = (eyez < minz_s1) ? minz_s1 : ((eyez > hiz) ? hiz : eyez);
	assign dxw  = (minx_s1 <<< 1) + SPAN_X_S - (eyex <<< 1);
	assign dzw  = (minz_s1 <<< 1) + SPAN_Z_S - (eyez <<< 1);

	always_ff @(posedge clk) begin
		if (rdy[2]) begin
			ndx_s2 <= clx - eyex;
			ndz_s2 <= clz - eyez;
			dx_s2  <= dxw[D_W-1:0];
			dz_s2  <= dzw[D_W-1:0];
		end
	end

	// S3: per-axis radius check, center and dot products
	logic [POS_W-1:0]        axw, azw;
	logic signed [D2_W-1:0]  sqx, sqz;
	logic signed [PD_W-1:0]  prx, prz;
	logic                    far_s3;
	logic [RAD_W-1:0]        ax_s3, az_s3;
	logic [D2_W-1:0]         ddx_s3, ddz_s3;
	logic signed [PD_W-1:0]  pdx_s3, pdz_s3;

	assign axw = ndx_s2[POS_W-1] ? $unsigned(-ndx_s2) : $unsigned(ndx_s2);
	assign azw = ndz_s2[POS_W-1] ? $unsigned(-ndz_s2) : $unsigned(ndz_s2);
	assign sqx = D2_W'(dx_s2) * D2_W'(dx_s2);
	assign sqz = D2_W'(dz_s2) * D2_W'(dz_s2);
	assign prx = PD_W'(dx_s2) * PD_W'(cfg.view_dir_x);
	assign prz = PD_W'(dz_s2) * PD_W'(cfg.view_dir_z);

	always_ff @(posedge clk) begin
		if (rdy[3]) begin
			far_s3 <= (axw > POS_W'(cfg.render_radius)) ||
			          (azw > POS_W'(cfg.render_radius));
			ax_s3  <= axw[RAD_W-1:0];
			az_s3  <= azw[RAD_W-1:0];
			ddx_s3 <= $unsigned(sqx);
			ddz_s3 <= $unsigned(sqz);
			pdx_s3 <= prx;
			pdz_s3 <= prz;
		end
	end

	// S4: gap squares, center distance and dot sums
	logic                 far_s4;
	logic [RR_W-1:0]      axx_s4, azz_s4;
	logic [D2_W-1:0]      d2_s4;
	logic signed [P_W-1:0] p_s4;

	always_ff @(posedge clk) begin
		if (rdy[4]) begin
			far_s4 <= far_s3;
			axx_s4 <= RR_W'(ax_s3) * RR_W'(ax_s3);
			azz_s4 <= RR_W'(az_s3) * RR_W'(az_s3);
			d2_s4  <= ddx_s3 + ddz_s3;
			p_s4   <= {pdx_s3[PD_W-1], pdx_s3} + {pdz_s3[PD_W-1], pdz_s3};
		end
	end

	// S5: radius and near decisions, |p|, d2 * f2 halves
	logic [RR_W:0]         gap2;
	logic [P_W-1:0]        paw;
	logic                  far_s5, near_s5, pneg_s5;
	logic [PA_W-1:0]       pa_s5;
	logic [DFH_W-1:0]      dfh_s5;
	logic [DFL_W-1:0]      dfl_s5;

	assign gap2 = {1'b0, axx_s4} + {1'b0, azz_s4};
	assign paw  = p_s4[P_W-1] ? $unsigned(-p_s4) : $unsigned(p_s4);

	always_ff @(posedge clk) begin
		if (rdy[5]) begin
			far_s5  <= far_s4 || (gap2 > {1'b0, rr_q});
			near_s5 <= (d2_s4 <= NEAR2);
			pneg_s5 <= p_s4[P_W-1];
			pa_s5   <= paw[PA_W-1:0];
			dfh_s5  <= DFH_W'(d2_s4[D2_W-1:DL_W]) * DFH_W'(f2_q);
			dfl_s5  <= DFL_W'(d2_s4[DL_W-1:0]) * DFL_W'(f2_q);
		end
	end

	// S6: |p| squared as partial products, d2 * f2 assembled
	logic             far_s6, near_s6, pneg_s6;
	logic [HH_W-1:0]  hh_s6;
	logic [HL_W-1:0]  hl_s6;
	logic [LL_W-1:0]  ll_s6;
	logic [Q_W-1:0]   q_s6;

	always_ff @(posedge clk) begin
		if (rdy[6]) begin
			far_s6  <= far_s5;
			near_s6 <= near_s5;
			pneg_s6 <= pneg_s5;
			hh_s6   <= HH_W'(pa_s5[PA_W-1:PL_W]) * HH_W'(pa_s5[PA_W-1:PL_W]);
			hl_s6   <= HL_W'(pa_s5[PA_W-1:PL_W]) * HL_W'(pa_s5[PL_W-1:0]);
			ll_s6   <= LL_W'(pa_s5[PL_W-1:0]) * LL_W'(pa_s5[PL_W-1:0]);
			q_s6    <= (Q_W'(dfh_s5) << DL_W) + Q_W'(dfl_s5);
		end
	end

	// S7: p squared summed, right side scaled by 49
	logic             far_s7, near_s7, pneg_s7;
	logic [P2_W-1:0]  p2_s7;
	logic [Q49_W-1:0] q49_s7;

	always_ff @(posedge clk) begin
		if (rdy[7]) begin
			far_s7  <= far_s6;
			near_s7 <= near_s6;
			pneg_s7 <= pneg_s6;
			p2_s7   <= (P2_W'(hh_s6) << (2 * PL_W)) + (P2_W'(hl_s6) << (PL_W + 1)) +
			           P2_W'(ll_s6);
			q49_s7  <= Q49_W'(q_s6) * Q49_W'(CONE_RHS_K);
		end
	end

	// S8: left side scaled by 400
	logic             far_s8, near_s8, pneg_s8;
	logic [L_W-1:0]   lhs_s8;
	logic [Q49_W-1:0] q49_s8;

	always_ff @(posedge clk) begin
		if (rdy[8]) begin
			far_s8  <= far_s7;
			near_s8 <= near_s7;
			pneg_s8 <= pneg_s7;
			lhs_s8  <= L_W'(p2_s7) * L_W'(CONE_LHS_K);
			q49_s8  <= q49_s7;
		end
	end

	// S9: cone compare and verdict priority, output register
	verdict_t verdict_nx;
	verdict_t verdict_s9;
	logic     in_cone;

	assign in_cone = CMP_W'(lhs_s8) < CMP_W'(q49_s8);

	always_comb begin
		if (far_s8) begin
			verdict_nx = VERDICT_FAR;
		end else if (near_s8) begin
			verdict_nx = VERDICT_NEAR;
		end else if (fzero_q) begin
			verdict_nx = VERDICT_ZERO_FWD;
		end else if (!pneg_s8 || in_cone) begin
			verdict_nx = VERDICT_IN_CONE;
		end else begin
			verdict_nx = VERDICT_BEHIND;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy[9]) verdict_s9 <= verdict_nx;
	end

	// Visible for near, zero forward and inside cone
	logic is_visible;

	always_comb begin
		case (verdict_s9) inside
			VERDICT_NEAR, VERDICT_ZERO_FWD, VERDICT_IN_CONE: is_visible = 1'b1;
			default:                                         is_visible = 1'b0;
		endcase
	end

	assign m_tdata = {{(OUT_DATA_W-4){1'b0}}, verdict_s9, is_visible};

endmodule

// File: tb/sv/cull_checker.sv
// Checker for the chunk visibility cull block: predicts each verdict and compares.
`timescale 1ns / 100ps

module cull_checker
	import cvc_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_tvalid,
	input  logic                  s_tready,
	input  logic [IN_DATA_W-1:0]  s_tdata,   // chunk_x [15:0], chunk_z [31:16]
	input  logic                  m_tvalid,
	input  logic                  m_tready,
	input  logic [OUT_DATA_W-1:0] m_tdata,   // is_visible [0], verdict [3:1], zero pad
	input  logic                  cfg_we,
	input  logic [ADDR_W-1:0]     cfg_addr,
	input  logic [CFG_DATA_W-1:0] cfg_wdata,
	input  logic                  end_of_test,
	output int                    pending,
	output int                    errors
);

	// Footprint span and near limit in fixed point, doubled units for the near test
	localparam longint SPAN_X   = longint'(DEF_CHUNK_SIZE_X) << DEF_FRACTION_BITS;
	localparam longint SPAN_Z   = longint'(DEF_CHUNK_SIZE_Z) << DEF_FRACTION_BITS;
	localparam longint NEAR_LIM = longint'(2 * NEAR_BLOCKS) << DEF_FRACTION_BITS;
	localparam int     MAX_SHOWN = 40;

	// Local copy of the camera registers
	logic signed [EYE_W-1:0] cam_eye_x, cam_eye_z;
	logic signed [DIR_W-1:0] cam_dir_x, cam_dir_z;
	logic        [RAD_W-1:0] cam_radius;

	verdict_t verdicts_due[$];
	verdict_t want_v;
	int       fails;
	int       words_in;
	int       words_out;
	int       reg_writes;
	int       hits[5];
	bit       closed;

	assign errors = fails;

	function automatic longint clamp_to(input longint v, input longint lo, input longint hi);
		return (v < lo) ? lo : ((v > hi) ? hi : v);
	endfunction

	// Expected verdict for one chunk under the current camera
	function automatic verdict_t cull_verdict(input logic signed [CHUNK_W-1:0] cx,
			input logic signed [CHUNK_W-1:0] cz);
		longint min_x, min_z, gap_x, gap_z, rad, cdx, cdz, d2, f2, dot;
		logic [127:0] lhs, rhs;
		min_x = longint'(cx) * SPAN_X;
		min_z = longint'(cz) * SPAN_Z;
		gap_x = clamp_to(longint'(cam_eye_x), min_x, min_x + SPAN_X) - longint'(cam_eye_x);
		gap_z = clamp_to(longint'(cam_eye_z), min_z, min_z + SPAN_Z) - longint'(cam_eye_z);
		if (gap_x < 0) gap_x = -gap_x;
		if (gap_z < 0) gap_z = -gap_z;
		rad = longint'(cam_radius);
		if (gap_x > rad || gap_z > rad || gap_x * gap_x + gap_z * gap_z > rad * rad)
			return VERDICT_FAR;
		// eye to center, doubled so odd spans stay exact
		cdx = 2 * min_x + SPAN_X - 2 * longint'(cam_eye_x);
		cdz = 2 * min_z + SPAN_Z - 2 * longint'(cam_eye_z);
		d2 = cdx * cdx + cdz * cdz;
		if (d2 <= NEAR_LIM * NEAR_LIM)
			return VERDICT_NEAR;
		if (cam_dir_x == 0 && cam_dir_z == 0)
			return VERDICT_ZERO_FWD;
		dot = cdx * longint'(cam_dir_x) + cdz * longint'(cam_dir_z);
		if (dot >= 0)
			return VERDICT_IN_CONE;
		// cos > -0.35 with squares: 400 dot^2 < 49 d2 f2
		f2 = longint'(cam_dir_x) * longint'(cam_dir_x) + longint'(cam_dir_z) * longint'(cam_dir_z);
		lhs = 128'(-dot);
		lhs = lhs * lhs * 128'(CONE_LHS_K);
		rhs = 128'(d2) * 128'(f2) * 128'(CONE_RHS_K);
		return (lhs < rhs) ? VERDICT_IN_CONE : VERDICT_BEHIND;
	endfunction

	task automatic note_mismatch(input string what, input int got, input int want);
		fails++;
		if (fails <= MAX_SHOWN)
			$display("%0t mismatch on %s: got %0d, expected %0d (result word %0d)",
				$realtime, what, got, want, words_out);
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cam_eye_x  <= '0;
			cam_eye_z  <= '0;
			cam_dir_x  <= '0;
			cam_dir_z  <= '0;
			cam_radius <= RAD_RESET;
			verdicts_due.delete();
			pending <= 0;
		end else begin
			// register writes
			if (cfg_we) begin
				reg_writes++;
				case (reg_idx_t'(cfg_addr))
					REG_EYE_POS_X:     cam_eye_x  <= cfg_wdata[EYE_W-1:0];
					REG_EYE_POS_Z:     cam_eye_z  <= cfg_wdata[EYE_W-1:0];
					REG_VIEW_DIR_X:    cam_dir_x  <= cfg_wdata[DIR_W-1:0];
					REG_VIEW_DIR_Z:    cam_dir_z  <= cfg_wdata[DIR_W-1:0];
					REG_RENDER_RADIUS: cam_radius <= cfg_wdata[RAD_W-1:0];
					default: ;
				endcase
			end

			// result words, oldest expectation first
			if (m_tvalid && m_tready) begin
				words_out++;
				if (verdicts_due.size() == 0) begin
					note_mismatch("unexpected result word", int'(m_tdata), -1);
				end else begin
					want_v = verdicts_due.pop_front();
					if (m_tdata[0] != (want_v inside {VERDICT_NEAR, VERDICT_ZERO_FWD,
							VERDICT_IN_CONE}))
						note_mismatch("is_visible", int'(m_tdata[0]), int'(!m_tdata[0]));
					if (m_tdata[3:1] != want_v)
						note_mismatch("verdict", int'(m_tdata[3:1]), int'(want_v));
					if (m_tdata[OUT_DATA_W-1:4] != '0)
						note_mismatch("pad bits", int'(m_tdata[OUT_DATA_W-1:4]), 0);
				end
			end

			// chunk words
			if (s_tvalid && s_tready) begin
				want_v = cull_verdict(s_tdata[CHUNK_W-1:0], s_tdata[2*CHUNK_W-1:CHUNK_W]);
				verdicts_due.push_back(want_v);
				hits[int'(want_v)]++;
				words_in++;
			end
			pending <= verdicts_due.size();

			if (end_of_test && !closed) begin
				closed = 1'b1;
				if (verdicts_due.size() != 0)
					note_mismatch("results never delivered", 0, verdicts_due.size());
				$display("covered %0d chunk words, %0d results, %0d register writes",
					words_in, words_out, reg_writes);
				$display("verdicts: far %0d, near %0d, zero forward %0d, in cone %0d, behind %0d",
					hits[0], hits[1], hits[2], hits[3], hits[4]);
			end
		end
	end

endmodule

// File: tb/sv/tb.sv
// Testbench top: stimulus, camera settings, stall patterns and the final verdict.
`timescale 1ns / 100ps

module tb;
	import cvc_pkg::*;

	localparam int SPAN_LOG2    = $clog2(DEF_CHUNK_SIZE_X) + DEF_FRACTION_BITS;
	localparam int EYE_MAX      = (1 << (EYE_W - 1)) - 1;
	localparam int EYE_MIN      = -(1 << (EYE_W - 1));
	localparam int RAD_MAX      = (1 << RAD_W) - 1;
	localparam int PHASES       = 12;
	localparam int PHASE_WORDS  = 74;
	localparam int HOLD_PHASE   = 3;
	localparam int HOLD_CYCLES  = 400;
	localparam int DRAIN_CYCLES = 16;
	localparam int IDLE_LIMIT   = 4000;

	logic                  clk = 1'b0;
	logic                  arst_n;
	logic                  s_tvalid;
	logic                  s_tready;
	logic [IN_DATA_W-1:0]  s_tdata;   // chunk_x [15:0], chunk_z [31:16]
	logic                  m_tvalid;
	logic                  m_tready;
	logic [OUT_DATA_W-1:0] m_tdata;   // is_visible [0], verdict [3:1], zero pad
	logic                  cfg_we;
	logic [ADDR_W-1:0]     cfg_addr;
	logic [CFG_DATA_W-1:0] cfg_wdata;
	logic                  end_of_test;
	int                    pending;
	int                    errors;
	bit                    hold_req;
	int                    burst_left;
	int                    idle_cycles;

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	chunk_visibility_cull_core dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.cfg_we    (cfg_we),
		.cfg_addr  (cfg_addr),
		.cfg_wdata (cfg_wdata)
	);

	cull_checker chk (
		.clk         (clk),
		.arst_n      (arst_n),
		.s_tvalid    (s_tvalid),
		.s_tready    (s_tready),
		.s_tdata     (s_tdata),
		.m_tvalid    (m_tvalid),
		.m_tready    (m_tready),
		.m_tdata     (m_tdata),
		.cfg_we      (cfg_we),
		.cfg_addr    (cfg_addr),
		.cfg_wdata   (cfg_wdata),
		.end_of_test (end_of_test),
		.pending     (pending),
		.errors      (errors)
	);

	// Watchdog: too long without any word moving ends the run
	always @(posedge clk) begin
		if (!arst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("watchdog: no word moved for %0d cycles", IDLE_LIMIT);
			$display("RESULT: ERROR");
			$finish;
		end
	end

	// Receiver: stall patterns in segments, plus one long hold-off on request
	initial begin : receiver
		int   mode;
		int   span;
		int   k;
		logic [7:0] mask;
		bit   held;
		held = 1'b0;
		m_tready = 1'b0;
		do @(posedge clk); while (!arst_n);
		forever begin
			if (hold_req && !held) begin
				held = 1'b1;
				m_tready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
			end else begin
				mode = $urandom_range(0, 3);
				span = $urandom_range(8, 60);
				mask = 8'($urandom_range(1, 255));
				for (k = 0; k < span; k++) begin
					case (mode)
						0: m_tready <= 1'b1;
						1: m_tready <= mask[k % 8];
						2: m_tready <= ($urandom_range(0, 3) != 0);
						default: m_tready <= ($urandom_range(0, 1) != 0);
					endcase
					@(posedge clk);
				end
			end
		end
	end

	// One chunk word, held until taken; bursts end with a random gap
	task automatic push_chunk(input int cx, input int cz);
		int gap;
		s_tvalid <= 1'b1;
		s_tdata  <= {CHUNK_W'(cz), CHUNK_W'(cx)};
		do @(posedge clk); while (!s_tready);
		burst_left--;
		if (burst_left <= 0) begin
			burst_left = $urandom_range(1, 24);
			gap = $urandom_range(0, 6);
			if (gap > 0) begin
				s_tvalid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
	endtask

	// Stop sending and wait until every result is back and the pipe is empty
	task automatic settle();
		s_tvalid <= 1'b0;
		do @(posedge clk); while (pending != 0);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic load_camera(input int ex, input int ez, input int dx, input int dz,
			input int rad);
		cfg_we    <= 1'b1;
		cfg_addr  <= REG_EYE_POS_X;
		cfg_wdata <= CFG_DATA_W'(ex);
		@(posedge clk);
		cfg_addr  <= REG_EYE_POS_Z;
		cfg_wdata <= CFG_DATA_W'(ez);
		@(posedge clk);
		cfg_addr  <= REG_VIEW_DIR_X;
		cfg_wdata <= CFG_DATA_W'(dx);
		@(posedge clk);
		cfg_addr  <= REG_VIEW_DIR_Z;
		cfg_wdata <= CFG_DATA_W'(dz);
		@(posedge clk);
		cfg_addr  <= REG_RENDER_RADIUS;
		cfg_wdata <= CFG_DATA_W'(rad);
		@(posedge clk);
		cfg_we    <= 1'b0;
	endtask

	function automatic int rand_eye();
		case ($urandom_range(0, 7))
			0: return EYE_MAX;
			1: return EYE_MIN;
			2, 3, 4: return int'($urandom_range(0, 1 << 18)) - (1 << 17);
			default: return int'($urandom) >>> (32 - EYE_W);
		endcase
	endfunction

	function automatic int rand_dir();
		case ($urandom_range(0, 5))
			0: return 0;
			1, 2: return int'($urandom_range(0, 8)) - 4;
			default: return int'($urandom) >>> (32 - DIR_W);
		endcase
	endfunction

	function automatic int rand_radius();
		case ($urandom_range(0, 9))
			0: return 0;
			1: return RAD_MAX;
			2, 3, 4: return int'($urandom_range(0, RAD_MAX));
			default: return int'($urandom_range(0, 48 << DEF_FRACTION_BITS));
		endcase
	endfunction

	// Stimulus and verdict
	initial begin : stimulus
		int ph, n, ex, ez, dx, dz, rad, ecx, ecz, reach, sel, cx, cz;
		arst_n      = 1'b0;
		s_tvalid    = 1'b0;
		s_tdata     = '0;
		cfg_we      = 1'b0;
		cfg_addr    = REG_EYE_POS_X;
		cfg_wdata   = '0;
		end_of_test = 1'b0;
		hold_req    = 1'b0;
		burst_left  = 8;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Reset camera: eye at origin, no forward vector, 256 block radius
		push_chunk(0, 0);             // eye inside the chunk, near
		push_chunk(5, 5);             // zero forward
		push_chunk(16, 0);            // gap equals the radius exactly
		push_chunk(-17, 0);           // same tie on the negative side
		push_chunk(16, 1);            // just past the radius
		push_chunk(-1, -1);
		push_chunk(32767, 32767);
		push_chunk(-32768, -32768);
		push_chunk(32767, -32768);
		push_chunk(-32768, 32767);
		settle();

		// Eye at z = 8 blocks looking along +z
		load_camera(0, 8 << DEF_FRACTION_BITS, 0, 1, 256 << DEF_FRACTION_BITS);
		push_chunk(1, 0);             // center exactly 24 blocks away
		push_chunk(3, 0);             // perpendicular, dot product zero
		push_chunk(-3, 0);            // perpendicular on the other side
		push_chunk(0, 3);             // straight ahead
		push_chunk(0, -3);            // straight behind
		push_chunk(3, -1);            // slightly behind, still inside the cone
		push_chunk(6, -2);            // further behind, still inside the cone
		push_chunk(-2, -2);
		push_chunk(1, 1);
		settle();

		// Extreme and random cameras, chunks mostly within reach of the eye
		for (ph = 0; ph < PHASES; ph++) begin
			case (ph)
				0: begin
					ex = EYE_MAX; ez = EYE_MAX; dx = 32767; dz = -32768; rad = RAD_MAX;
				end
				1: begin
					ex = EYE_MIN; ez = EYE_MIN; dx = -32768; dz = 32767; rad = 0;
				end
				2: begin
					ex = rand_eye(); ez = rand_eye(); dx = 0; dz = 0;
					rad = $urandom_range(0, 64 << DEF_FRACTION_BITS);
				end
				default: begin
					ex = rand_eye(); ez = rand_eye(); dx = rand_dir(); dz = rand_dir();
					rad = rand_radius();
				end
			endcase
			load_camera(ex, ez, dx, dz, rad);
			if (ph == HOLD_PHASE)
				hold_req = 1'b1;
			ecx = ex >>> SPAN_LOG2;
			ecz = ez >>> SPAN_LOG2;
			reach = (rad >>> SPAN_LOG2) + 2;
			for (n = 0; n < PHASE_WORDS; n++) begin
				sel = $urandom_range(0, 99);
				if (sel < 40) begin
					cx = ecx + int'($urandom_range(0, 4)) - 2;
					cz = ecz + int'($urandom_range(0, 4)) - 2;
				end else if (sel < 85) begin
					cx = ecx + int'($urandom_range(0, 2 * reach)) - reach;
					cz = ecz + int'($urandom_range(0, 2 * reach)) - reach;
				end else begin
					cx = int'($urandom) >>> (32 - CHUNK_W);
					cz = int'($urandom) >>> (32 - CHUNK_W);
				end
				push_chunk(cx, cz);
			end
			settle();
		end

		end_of_test <= 1'b1;
		@(posedge clk);
		@(posedge clk);
		if (errors == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule
